/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define UTF8D_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("utf8 decoder check failed");
`define UTF8D_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("utf8 decoder check failed");
`else
`define UTF8D_ASSERT(label, prop)
`define UTF8D_ASSERT_NEXT(label, pre, post)
`endif

`endif

/* hw/rtl/utf8d_pkg.sv */
package utf8d_pkg;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned CntWidth = 3;

  localparam logic [7:0] ByteAsciiEnd  = 8'h80;
  localparam logic [7:0] ByteLead2Min  = 8'hC2;
  localparam logic [7:0] ByteLead3Min  = 8'hE0;
  localparam logic [7:0] ByteLead4Min  = 8'hF0;
  localparam logic [7:0] ByteLead5Min  = 8'hF8;
  localparam logic [7:0] ByteLead6Min  = 8'hFC;
  localparam logic [7:0] ByteLeadEnd   = 8'hFE;
  localparam logic [7:0] ContMask      = 8'hC0;
  localparam logic [7:0] ContTag       = 8'h80;
  localparam logic [7:0] Min2ndDefault = 8'h80;
  localparam logic [7:0] Min2ndE0      = 8'hA0;
  localparam logic [7:0] Min2ndF0      = 8'h90;
  localparam logic [7:0] Min2ndF8      = 8'h88;
  localparam logic [7:0] Min2ndFc      = 8'h84;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_e;

  typedef struct packed {
    logic [CpWidth-1:0]  partial;
    logic [CntWidth-1:0] remaining;
    logic [CntWidth-1:0] length;
    logic [7:0]          min_second;
    logic                awaiting_second;
  } utf8d_state_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [CntWidth-1:0] byte_count;
    status_e             status;
  } utf8d_result_t;

  localparam utf8d_state_t IdleState = '{
    partial:         '0,
    remaining:       '0,
    length:          '0,
    min_second:      Min2ndDefault,
    awaiting_second: 1'b0
  };

endpackage

/* hw/rtl/utf8d_step.sv */
module utf8d_step (
  input  utf8d_pkg::utf8d_state_t  state_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     end_of_input_i,
  input  logic                     long_forms_enable_i,
  output utf8d_pkg::utf8d_state_t  state_o,
  output logic                     res_valid_o,
  output utf8d_pkg::utf8d_result_t res_o
);
  import utf8d_pkg::*;

  logic [CntWidth-1:0] lead_len;
  logic [CpWidth-1:0]  lead_val;
  logic [7:0]          lead_min;
  logic                lead_bad;
  logic [CntWidth-1:0] taken;
  logic [CntWidth-1:0] rem_next;
  logic [CpWidth-1:0]  val_next;
  logic                cont_bad;

  // lead byte classification
  always_comb begin
    lead_len = '0;
    lead_val = '0;
    lead_min = Min2ndDefault;
    lead_bad = 1'b0;
    priority if (data_byte_i < ByteLead2Min) begin
      lead_bad = 1'b1;
    end else if (data_byte_i < ByteLead3Min) begin
      lead_len = CntWidth'(2);
      lead_val = CpWidth'(data_byte_i[4:0]);
    end else if (data_byte_i < ByteLead4Min) begin
      lead_len = CntWidth'(3);
      lead_val = CpWidth'(data_byte_i[3:0]);
      if (data_byte_i == ByteLead3Min) lead_min = Min2ndE0;
    end else if (data_byte_i < ByteLead5Min && long_forms_enable_i) begin
      lead_len = CntWidth'(4);
      lead_val = CpWidth'(data_byte_i[2:0]);
      if (data_byte_i == ByteLead4Min) lead_min = Min2ndF0;
    end else if (data_byte_i < ByteLead6Min && long_forms_enable_i) begin
      lead_len = CntWidth'(5);
      lead_val = CpWidth'(data_byte_i[1:0]);
      if (data_byte_i == ByteLead5Min) lead_min = Min2ndF8;
    end else if (data_byte_i < ByteLeadEnd && long_forms_enable_i) begin
      lead_len = CntWidth'(6);
      lead_val = CpWidth'(data_byte_i[0]);
      if (data_byte_i == ByteLead6Min) lead_min = Min2ndFc;
    end else begin
      lead_bad = 1'b1;
    end
  end

  assign taken    = state_i.length - state_i.remaining + CntWidth'(1);
  assign rem_next = state_i.remaining - CntWidth'(1);
  assign val_next = {state_i.partial[CpWidth-7:0], data_byte_i[5:0]};
  assign cont_bad = ((data_byte_i & ContMask) != ContTag) ||
                    (state_i.awaiting_second && (data_byte_i < state_i.min_second));

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{code_point: '0, byte_count: '0, status: ST_OK};
    if (state_i.remaining == '0) begin
      priority if (data_byte_i < ByteAsciiEnd) begin
        res_valid_o      = 1'b1;
        res_o.code_point = CpWidth'(data_byte_i);
        res_o.byte_count = CntWidth'(1);
      end else if (lead_bad) begin
        res_valid_o      = 1'b1;
        res_o.byte_count = CntWidth'(1);
        res_o.status     = ST_INVALID;
        state_o          = IdleState;
      end else if (end_of_input_i) begin
        res_valid_o      = 1'b1;
        res_o.byte_count = CntWidth'(1);
        res_o.status     = ST_INCOMPLETE;
        state_o          = IdleState;
      end else begin
        state_o.partial         = lead_val;
        state_o.length          = lead_len;
        state_o.remaining       = lead_len - CntWidth'(1);
        state_o.min_second      = lead_min;
        state_o.awaiting_second = 1'b1;
      end
    end else begin
      priority if (cont_bad) begin
        res_valid_o      = 1'b1;
        res_o.byte_count = taken;
        res_o.status     = ST_INVALID;
        state_o          = IdleState;
      end else if (rem_next == '0) begin
        res_valid_o      = 1'b1;
        res_o.code_point = val_next;
        res_o.byte_count = taken;
        state_o          = IdleState;
      end else if (end_of_input_i) begin
        res_valid_o      = 1'b1;
        res_o.byte_count = taken;
        res_o.status     = ST_INCOMPLETE;
        state_o          = IdleState;
      end else begin
        state_o.partial         = val_next;
        state_o.remaining       = rem_next;
        state_o.awaiting_second = 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/utf8d_out_reg.sv */
module utf8d_out_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     res_valid_i,
  input  utf8d_pkg::utf8d_result_t res_i,
  input  logic                     out_stall_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  output utf8d_pkg::utf8d_result_t res_o
);
  import utf8d_pkg::*;

  logic          valid_q, valid_d;
  utf8d_result_t res_q;
  logic          load;

  // slot frees up when empty or when the held word leaves this cycle
  assign free_o  = !valid_q || !out_stall_i;
  assign load    = adv_i && res_valid_i;
  assign valid_d = free_o ? load : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* hw/rtl/utf8_code_point_decoder_top.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_stall_o  | data_byte_i, end_of_input_i
// out     | output    | out_valid_o/out_stall_i| code_point_o, byte_count_o, status_o
// cfg     | input     | cfg_we_i               | cfg_wdata_i (long_forms_enable)
//
// one byte per cycle while in is not stalled: a byte is registered in the input
// register, then decoded against the sequence state into the result register
// bytes that do not end a character update the state only and give no word
// a stall on out holds the result register and stalls in only while a byte
// waits in the input register
// reset empties both registers, idles the decoder and sets long_forms_enable
module utf8_code_point_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_input_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [utf8d_pkg::CpWidth-1:0] code_point_o,
  output logic [utf8d_pkg::CntWidth-1:0] byte_count_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i
);
  import utf8d_pkg::*;
  `include "assert_macros.svh"

  logic          in_valid_q, in_valid_d;
  logic [7:0]    byte_q;
  logic          end_q;
  logic          long_en_q;
  utf8d_state_t  state_q, state_d, step_state;
  logic          step_res_valid;
  utf8d_result_t step_res, out_res;
  logic          out_free;
  logic          adv;
  logic          in_take;

  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !adv);
  assign state_d    = adv ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= IdleState;
      long_en_q  <= 1'b1;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
      if (cfg_we_i) begin
        long_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      end_q  <= end_of_input_i;
    end
  end

  utf8d_step u_step (
    .state_i             (state_q),
    .data_byte_i         (byte_q),
    .end_of_input_i      (end_q),
    .long_forms_enable_i (long_en_q),
    .state_o             (step_state),
    .res_valid_o         (step_res_valid),
    .res_o               (step_res)
  );

  utf8d_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .res_valid_i (step_res_valid),
    .res_i       (step_res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign code_point_o = out_res.code_point;
  assign byte_count_o = out_res.byte_count;
  assign status_o     = out_res.status;

  // failed or cut-off characters never carry a value
  `UTF8D_ASSERT(a_err_zero_cp, out_valid_o && (status_o != ST_OK) |-> code_point_o == '0)
  // a one-byte character is plain ascii
  `UTF8D_ASSERT(a_single_ascii,
    out_valid_o && (status_o == ST_OK) && (byte_count_o == CntWidth'(1)) |-> code_point_o < 31'h80)
  `UTF8D_ASSERT(a_count_range,
    out_valid_o |-> (byte_count_o != '0) && (byte_count_o <= CntWidth'(6)))
  // mid-sequence the remaining count stays below the length fixed by the lead
  `UTF8D_ASSERT(a_remaining_lt_len,
    state_q.remaining != '0 |-> state_q.remaining < state_q.length)
  `UTF8D_ASSERT_NEXT(a_no_adv_holds_state, !adv, $stable(state_q))

endmodule
